[rtl/sorted_table_binary_search_macros.svh]
// assertion macros used by the checker file
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define STBS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define STBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/stbs_pkg.sv]
package stbs_pkg;

   localparam int DEPTH_DEFAULT     = 1024;
   localparam int KEY_WIDTH_DEFAULT = 32;

   // request field widths
   localparam int ENTRY_INDEX_W = 10;
   localparam int KEY_W         = 32;
   localparam int RANGE_LOW_W   = 10;
   localparam int RANGE_HIGH_W  = 11;
   localparam int POSITION_W    = 11;

   // signed bound registers, hold -1024 .. 1024
   localparam int IDX_W = 12;

   localparam logic [POSITION_W-1:0] POS_NONE = '1;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef struct packed {
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic [KEY_W-1:0]         key;
      logic [RANGE_LOW_W-1:0]   range_low;
      logic [RANGE_HIGH_W-1:0]  range_high;
   } req_fields_type;

   typedef struct packed {
      logic load;      // latch a search request
      logic wr_en;     // write one table entry
      logic probe;     // check range, issue first read
      logic step;      // compare read data, issue next read
      logic out_load;  // move result into the response register
   } dp_cmd_type;

   typedef struct packed {
      logic empty;       // range empty before the first probe
      logic hit;         // probed entry equals the key
      logic next_empty;  // narrowed range is empty
   } dp_sts_type;

endpackage

[rtl/sorted_table_binary_search.sv]
// channel  direction  payload
// req_     in         tuser: cmd (0 write, 1 search)
//                     tdata: entry_index, key, range_low, range_high
// rsp_     out        tuser: found; tdata: position (-1 when not found)
//
// a write request gives no response
// a search makes at most 11 probes over a 1024-entry range, one probe per
// cycle on the table read port
// reset is synchronous and active high; it clears the controller only, the table
// holds garbage until written
// a finished response waits in its own register while the block takes new requests
module sorted_table_binary_search #(
   parameter int DEPTH     = stbs_pkg::DEPTH_DEFAULT,
   parameter int KEY_WIDTH = stbs_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [9:0] entry_index, [41:10] key, [51:42] range_low, [62:52] range_high,
   // [63] zero
   input  logic [63:0] req_tdata,
   // [0] cmd
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [10:0] position, [15:11] zero
   output logic [15:0] rsp_tdata,
   // [0] found
   output logic        rsp_tuser
);
   import stbs_pkg::*;

   localparam int KEY_LSB  = ENTRY_INDEX_W;
   localparam int LOW_LSB  = KEY_LSB + KEY_W;
   localparam int HIGH_LSB = LOW_LSB + RANGE_LOW_W;

   req_fields_type        req_fields;
   dp_cmd_type            dp_cmd;
   dp_sts_type            dp_sts;
   logic [POSITION_W-1:0] rsp_position;

   // unpack the request word
   assign req_fields.entry_index = req_tdata[ENTRY_INDEX_W-1:0];
   assign req_fields.key         = req_tdata[LOW_LSB-1:KEY_LSB];
   assign req_fields.range_low   = req_tdata[HIGH_LSB-1:LOW_LSB];
   assign req_fields.range_high  = req_tdata[HIGH_LSB+RANGE_HIGH_W-1:HIGH_LSB];

   // sequencer: accept, probe loop, response handoff
   stbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd),
      .dp_sts     (dp_sts)
   );

   // table memory, bounds, key compare and response register
   stbs_datapath #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .req_fields   (req_fields),
      .dp_cmd       (dp_cmd),
      .dp_sts       (dp_sts),
      .rsp_found    (rsp_tuser),
      .rsp_position (rsp_position)
   );

   assign rsp_tdata = 16'(rsp_position);

endmodule

[rtl/stbs_ctrl.sv]
module stbs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output stbs_pkg::dp_cmd_type dp_cmd,
   input  stbs_pkg::dp_sts_type dp_sts
);
   import stbs_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PROBE,
      S_STEP,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      dp_cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == CMD_SEARCH) begin
                  dp_cmd.load = 1'b1;
                  state_in    = S_PROBE;
               end else begin
                  dp_cmd.wr_en = 1'b1;
               end
            end
         end
         S_PROBE: begin
            dp_cmd.probe = 1'b1;
            state_in     = dp_sts.empty ? S_FINISH : S_STEP;
         end
         S_STEP: begin
            dp_cmd.step = 1'b1;
            if (dp_sts.hit || dp_sts.next_empty) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               dp_cmd.out_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

[rtl/stbs_datapath.sv]
module stbs_datapath #(
   parameter int DEPTH     = stbs_pkg::DEPTH_DEFAULT,
   parameter int KEY_WIDTH = stbs_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  stbs_pkg::req_fields_type            req_fields,
   input  stbs_pkg::dp_cmd_type                dp_cmd,
   output stbs_pkg::dp_sts_type                dp_sts,
   output logic                                rsp_found,
   output logic [stbs_pkg::POSITION_W-1:0]     rsp_position
);
   import stbs_pkg::*;

   localparam int          AW      = $clog2(DEPTH);
   localparam int          HI_MAX  = DEPTH - 1;
   localparam logic [31:0] DEPTH_U = 32'(DEPTH);

   logic signed [KEY_WIDTH-1:0] mem [DEPTH];

   logic signed [IDX_W-1:0]     lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic signed [KEY_WIDTH-1:0] key_ff, key_in, rdata_ff;
   logic                        res_found_ff, res_found_in;
   logic [POSITION_W-1:0]       res_pos_ff, res_pos_in;
   logic                        out_found_ff;
   logic [POSITION_W-1:0]       out_pos_ff;

   logic signed [63:0]          key64;
   logic signed [IDX_W-1:0]     rh;
   logic signed [31:0]          rh32;
   logic [31:0]                 wr_idx32, rd_idx32;
   logic                        wr_ok;
   logic signed [IDX_W-1:0]     mid0, hi_a, lo_b, mid_a, mid_b, rd_mid;
   logic                        empty_a, empty_b, greater;

   // key sign extended, then wrapped to the table width
   assign key64    = 64'(signed'(req_fields.key));
   assign key_in   = key64[KEY_WIDTH-1:0];

   assign rh       = IDX_W'(signed'(req_fields.range_high));
   assign rh32     = 32'(rh);
   assign wr_idx32 = 32'(req_fields.entry_index);
   assign wr_ok    = (wr_idx32 < DEPTH_U);

   // first midpoint from the latched bounds
   assign mid0     = lo_ff + ((hi_ff - lo_ff) >>> 1);

   // both possible next probes, picked by the compare
   assign hi_a     = mid_ff - IDX_W'(1);
   assign lo_b     = mid_ff + IDX_W'(1);
   assign empty_a  = (lo_ff > hi_a);
   assign empty_b  = (lo_b > hi_ff);
   assign mid_a    = lo_ff + ((hi_a - lo_ff) >>> 1);
   assign mid_b    = lo_b + ((hi_ff - lo_b) >>> 1);
   assign greater  = (rdata_ff > key_ff);

   assign dp_sts.empty      = (lo_ff > hi_ff);
   assign dp_sts.hit        = (rdata_ff == key_ff);
   assign dp_sts.next_empty = greater ? empty_a : empty_b;

   assign rd_mid   = dp_cmd.probe ? mid0 : (greater ? mid_a : mid_b);
   assign rd_idx32 = 32'(unsigned'(rd_mid));

   always_comb begin
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      if (dp_cmd.load) begin
         lo_in = IDX_W'(req_fields.range_low);
         hi_in = (rh32 > HI_MAX) ? IDX_W'(HI_MAX) : rh;
      end else if (dp_cmd.probe) begin
         mid_in       = mid0;
         res_found_in = 1'b0;
         res_pos_in   = POS_NONE;
      end else if (dp_cmd.step) begin
         if (dp_sts.hit) begin
            res_found_in = 1'b1;
            res_pos_in   = mid_ff[POSITION_W-1:0];
         end else begin
            res_found_in = 1'b0;
            res_pos_in   = POS_NONE;
            if (greater) begin
               hi_in  = hi_a;
               mid_in = mid_a;
            end else begin
               lo_in  = lo_b;
               mid_in = mid_b;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      if (dp_cmd.load) begin
         key_ff <= key_in;
      end
      if (dp_cmd.out_load) begin
         out_found_ff <= res_found_ff;
         out_pos_ff   <= res_pos_ff;
      end
   end

   // table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (dp_cmd.wr_en && wr_ok) begin
         mem[wr_idx32[AW-1:0]] <= key_in;
      end
      rdata_ff <= mem[rd_idx32[AW-1:0]];
   end

   assign rsp_found    = out_found_ff;
   assign rsp_position = out_pos_ff;

endmodule

[rtl/stbs_checker.sv]
`include "sorted_table_binary_search_macros.svh"

module stbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);
   import stbs_pkg::*;

   logic search_accept;
   assign search_accept = req_tvalid && req_tready && (req_tuser == CMD_SEARCH)
                          && (req_tdata[63] == 1'b0);

   `STBS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response dropped or changed while stalled")
   `STBS_ASSERT_NOW(a_miss_pos, rsp_tvalid && !rsp_tuser, rsp_tdata[10:0] == POS_NONE, "miss without position -1")
   `STBS_ASSERT_NOW(a_hit_pos, rsp_tvalid && rsp_tuser, !rsp_tdata[10] && (rsp_tdata[15:11] == 5'd0), "hit with negative or padded position")
   `STBS_ASSERT_NEXT(a_busy, search_accept, !req_tready, "request taken while a search runs")

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
